### design/color_spec_parser_top_assert.svh
// ---------------------------------------------------------------------------
// color_spec_parser_top_assert.svh
// assertion macros shared by the color spec parser
// ---------------------------------------------------------------------------
`ifndef COLOR_SPEC_PARSER_TOP_ASSERT_SVH
`define COLOR_SPEC_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define CSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/csp_pkg.sv
// ---------------------------------------------------------------------------
// csp_pkg
// constants, types and the color name rom of the color spec parser
// ---------------------------------------------------------------------------
package csp_pkg;

  localparam int NAME_COUNT_DEF   = 148;
  localparam int NAME_MAX_LEN_DEF = 20;
  localparam int ROM_SIZE         = 148;
  localparam int ROM_CHARS        = 20;
  localparam int ROM_BITS         = 8 * ROM_CHARS;
  localparam int POS_W            = 6;
  localparam logic [POS_W-1:0] LEN_SAT = 6'd63;

  // status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_EMPTY    = 4'd1;
  localparam logic [3:0] ST_HEX_DIG  = 4'd2;
  localparam logic [3:0] ST_HEX_LEN  = 4'd3;
  localparam logic [3:0] ST_MISSING  = 4'd4;
  localparam logic [3:0] ST_OVER     = 4'd5;
  localparam logic [3:0] ST_COUNT    = 4'd6;
  localparam logic [3:0] ST_TRAILING = 4'd7;
  localparam logic [3:0] ST_UNKNOWN  = 4'd8;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COMMA = 8'h2c;

  // per-character command to the name cells
  typedef struct packed {
    logic             commit;
    logic             kill;
    logic             clear;
    logic [POS_W-1:0] pos;
    logic [7:0]       ch;
    logic [POS_W-1:0] clen;
  } cell_ctl_t;

  typedef logic [ROM_CHARS-1:0][7:0] name_chars_t;

  function automatic logic [ROM_BITS+23:0] ent(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b,
                                               input logic [ROM_BITS-1:0] s);
    return {r, g, b, s};
  endfunction

  function automatic int name_len(input logic [ROM_BITS-1:0] s);
    int n;
    n = 0;
    for (int p = 0; p < ROM_CHARS; p++) begin
      if (s[p*8 +: 8] != 8'd0) n = n + 1;
    end
    return n;
  endfunction

  // characters of a name in spelling order
  function automatic name_chars_t name_chars(input logic [ROM_BITS-1:0] s);
    name_chars_t o;
    int n;
    o = '0;
    n = name_len(s);
    for (int p = 0; p < ROM_CHARS; p++) begin
      if (p < n) o[p] = s[(n-1-p)*8 +: 8];
    end
    return o;
  endfunction

  function automatic logic [ROM_BITS+23:0] name_entry(input int idx);
    case (idx)
      0: return ent(240,248,255,"aliceblue");
      1: return ent(250,235,215,"antiquewhite");
      2: return ent(0,255,255,"aqua");
      3: return ent(127,255,212,"aquamarine");
      4: return ent(240,255,255,"azure");
      5: return ent(245,245,220,"beige");
      6: return ent(255,228,196,"bisque");
      7: return ent(0,0,0,"black");
      8: return ent(255,235,205,"blanchedalmond");
      9: return ent(0,0,255,"blue");
      10: return ent(138,43,226,{"blue","viol","et"});
      11: return ent(165,42,42,"brown");
      12: return ent(222,184,135,"burlywood");
      13: return ent(95,158,160,"cadetblue");
      14: return ent(127,255,0,"chartreuse");
      15: return ent(210,105,30,"chocolate");
      16: return ent(255,127,80,"coral");
      17: return ent(100,149,237,"cornflowerblue");
      18: return ent(255,248,220,"cornsilk");
      19: return ent(220,20,60,"crimson");
      20: return ent(0,255,255,"cyan");
      21: return ent(0,0,139,"darkblue");
      22: return ent(0,139,139,"darkcyan");
      23: return ent(184,134,11,"darkgoldenrod");
      24: return ent(169,169,169,"darkgray");
      25: return ent(0,100,0,"darkgreen");
      26: return ent(169,169,169,"darkgrey");
      27: return ent(189,183,107,"darkkhaki");
      28: return ent(139,0,139,"darkmagenta");
      29: return ent(85,107,47,"darkolivegreen");
      30: return ent(255,140,0,"darkorange");
      31: return ent(153,50,204,"darkorchid");
      32: return ent(139,0,0,"darkred");
      33: return ent(233,150,122,"darksalmon");
      34: return ent(143,188,143,"darkseagreen");
      35: return ent(72,61,139,"darkslateblue");
      36: return ent(47,79,79,"darkslategray");
      37: return ent(47,79,79,"darkslategrey");
      38: return ent(0,206,209,"darkturquoise");
      39: return ent(148,0,211,{"dark","viol","et"});
      40: return ent(255,20,147,"deeppink");
      41: return ent(0,191,255,"deepskyblue");
      42: return ent(105,105,105,"dimgray");
      43: return ent(105,105,105,"dimgrey");
      44: return ent(30,144,255,"dodgerblue");
      45: return ent(178,34,34,"firebrick");
      46: return ent(255,250,240,"floralwhite");
      47: return ent(34,139,34,"forestgreen");
      48: return ent(255,0,255,"fuchsia");
      49: return ent(220,220,220,"gainsboro");
      50: return ent(248,248,255,"ghostwhite");
      51: return ent(255,215,0,"gold");
      52: return ent(218,165,32,"goldenrod");
      53: return ent(128,128,128,"gray");
      54: return ent(0,128,0,"green");
      55: return ent(173,255,47,"greenyellow");
      56: return ent(128,128,128,"grey");
      57: return ent(240,255,240,"honeydew");
      58: return ent(255,105,180,"hotpink");
      59: return ent(205,92,92,"indianred");
      60: return ent(75,0,130,"indigo");
      61: return ent(255,255,240,"ivory");
      62: return ent(240,230,140,"khaki");
      63: return ent(230,230,250,"lavender");
      64: return ent(255,240,245,"lavenderblush");
      65: return ent(124,252,0,"lawngreen");
      66: return ent(255,250,205,"lemonchiffon");
      67: return ent(173,216,230,"lightblue");
      68: return ent(240,128,128,"lightcoral");
      69: return ent(224,255,255,"lightcyan");
      70: return ent(250,250,210,"lightgoldenrodyellow");
      71: return ent(211,211,211,"lightgray");
      72: return ent(144,238,144,"lightgreen");
      73: return ent(211,211,211,"lightgrey");
      74: return ent(255,182,193,"lightpink");
      75: return ent(255,160,122,"lightsalmon");
      76: return ent(32,178,170,"lightseagreen");
      77: return ent(135,206,250,"lightskyblue");
      78: return ent(119,136,153,"lightslategray");
      79: return ent(119,136,153,"lightslategrey");
      80: return ent(176,196,222,"lightsteelblue");
      81: return ent(255,255,224,"lightyellow");
      82: return ent(0,255,0,"lime");
      83: return ent(50,205,50,"limegreen");
      84: return ent(250,240,230,"linen");
      85: return ent(255,0,255,"magenta");
      86: return ent(128,0,0,"maroon");
      87: return ent(102,205,170,"mediumaquamarine");
      88: return ent(0,0,205,"mediumblue");
      89: return ent(186,85,211,"mediumorchid");
      90: return ent(147,112,219,"mediumpurple");
      91: return ent(60,179,113,"mediumseagreen");
      92: return ent(123,104,238,"mediumslateblue");
      93: return ent(0,250,154,"mediumspringgreen");
      94: return ent(72,209,204,"mediumturquoise");
      95: return ent(199,21,133,{"medium","viol","etred"});
      96: return ent(25,25,112,"midnightblue");
      97: return ent(245,255,250,"mintcream");
      98: return ent(255,228,225,"mistyrose");
      99: return ent(255,228,181,"moccasin");
      100: return ent(255,222,173,"navajowhite");
      101: return ent(0,0,128,"navy");
      102: return ent(253,245,230,"oldlace");
      103: return ent(128,128,0,"olive");
      104: return ent(107,142,35,"olivedrab");
      105: return ent(255,165,0,"orange");
      106: return ent(255,69,0,"orangered");
      107: return ent(218,112,214,"orchid");
      108: return ent(238,232,170,"palegoldenrod");
      109: return ent(152,251,152,"palegreen");
      110: return ent(175,238,238,"paleturquoise");
      111: return ent(219,112,147,{"pale","viol","etred"});
      112: return ent(255,239,213,"papayawhip");
      113: return ent(255,218,185,"peachpuff");
      114: return ent(205,133,63,"peru");
      115: return ent(255,192,203,"pink");
      116: return ent(221,160,221,"plum");
      117: return ent(176,224,230,"powderblue");
      118: return ent(128,0,128,"purple");
      119: return ent(102,51,153,"rebeccapurple");
      120: return ent(255,0,0,"red");
      121: return ent(188,143,143,"rosybrown");
      122: return ent(65,105,225,"royalblue");
      123: return ent(139,69,19,"saddlebrown");
      124: return ent(250,128,114,"salmon");
      125: return ent(244,164,96,"sandybrown");
      126: return ent(46,139,87,"seagreen");
      127: return ent(255,245,238,"seashell");
      128: return ent(160,82,45,"sienna");
      129: return ent(192,192,192,"silver");
      130: return ent(135,206,235,"skyblue");
      131: return ent(106,90,205,"slateblue");
      132: return ent(112,128,144,"slategray");
      133: return ent(112,128,144,"slategrey");
      134: return ent(255,250,250,"snow");
      135: return ent(0,255,127,"springgreen");
      136: return ent(70,130,180,"steelblue");
      137: return ent(210,180,140,"tan");
      138: return ent(0,128,128,"teal");
      139: return ent(216,191,216,"thistle");
      140: return ent(255,99,71,"tomato");
      141: return ent(64,224,208,"turquoise");
      142: return ent(238,130,238,{"viol","et"});
      143: return ent(245,222,179,"wheat");
      144: return ent(255,255,255,"white");
      145: return ent(245,245,245,"whitesmoke");
      146: return ent(255,255,0,"yellow");
      147: return ent(154,205,50,"yellowgreen");
      default: return '0;
    endcase
  endfunction

endpackage

### design/csp_name_cell.sv
// ---------------------------------------------------------------------------
// csp_name_cell
// one name matcher cell: holds the still-matching bit of one rom name
// ---------------------------------------------------------------------------
module csp_name_cell #(
  parameter int IDX          = 0,
  parameter int NAME_MAX_LEN = csp_pkg::NAME_MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csp_pkg::cell_ctl_t ctl,
  output logic               hit
);
  import csp_pkg::*;

  localparam logic [ROM_BITS+23:0] ENTRY = name_entry(IDX);
  localparam int                   LEN   = name_len(ENTRY[ROM_BITS-1:0]);
  localparam name_chars_t          CHARS = name_chars(ENTRY[ROM_BITS-1:0]);
  localparam logic                 IN_ROM = (IDX < ROM_SIZE);

  logic cand_r, cand_nxt, cand_eff, match;

  // compare the committed character against this name at its position
  always_comb begin
    match = (int'(ctl.pos) < NAME_MAX_LEN) && (int'(ctl.pos) < LEN) &&
            (ctl.pos < POS_W'(ROM_CHARS)) &&
            (CHARS[ctl.pos[$clog2(ROM_CHARS)-1:0]] == ctl.ch);
    cand_eff = ctl.commit ? (cand_r && !ctl.kill && match) : cand_r;
    cand_nxt = ctl.clear ? 1'b1 : cand_eff;
    hit      = IN_ROM && cand_eff && (LEN <= NAME_MAX_LEN) &&
               (ctl.clen == POS_W'(LEN));
  end

  // candidate bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= 1'b1;
    end else begin
      cand_r <= cand_nxt;
    end
  end

endmodule

### design/color_spec_parser_top.sv
// ---------------------------------------------------------------------------
// color_spec_parser_top
// color spec parser: hex, decimal triple or css name to rgb and status
// ---------------------------------------------------------------------------
// Usage: the input channel carries one byte of a color spec per word, with
// in_spec_last set on the final byte. Specs stream back to back at one byte
// per cycle while in_stall is low. A row of name cells, one per rom name,
// compares each byte against all names at once.
// On the last byte a result word goes to the middle stage and then to the
// output stage: red, green, blue and status (rgb zero unless status is ok).
// Bytes that are not last produce no word.
// A stalled result holds its payload; one more finished spec can wait in the
// middle stage, after which in_stall rises until the output drains.
// Reset (synchronous, rst_n low) clears all parse state, empties both result
// stages and sets every name cell back to matching.
// ---------------------------------------------------------------------------
module color_spec_parser_top #(
  parameter int NAME_COUNT   = csp_pkg::NAME_COUNT_DEF,
  parameter int NAME_MAX_LEN = csp_pkg::NAME_MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_spec_char,
  input  logic       in_spec_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [3:0] out_status
);
  import csp_pkg::*;

  `include "color_spec_parser_top_assert.svh"

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_NUM   = 2'd1;
  localparam logic [1:0] PH_AFTER = 2'd2;
  localparam logic [1:0] PH_TAIL  = 2'd3;

  typedef struct packed {
    logic [1:0]  phase;
    logic [2:0]  count;
    logic [8:0]  value;
    logic [23:0] store;
    logic [3:0]  err;
  } dec_t;

  localparam dec_t DEC_RST = '{phase: PH_LEAD, count: 3'd0, value: 9'd0,
                               store: 24'd0, err: ST_OK};

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic dec_t after_char(input dec_t d, input logic [7:0] c);
    dec_t o;
    o = d;
    if (!is_blank(c)) begin
      if (c == CH_COMMA) o.phase = (d.count < 3'd3) ? PH_LEAD : PH_TAIL;
      else o.err = (d.count != 3'd3) ? ST_COUNT : ST_TRAILING;
    end
    return o;
  endfunction

  function automatic dec_t accept_num(input dec_t d);
    dec_t o;
    o = d;
    if (d.value > 9'd255) begin
      o.err = ST_OVER;
    end else begin
      if (d.count < 3'd3) o.store[d.count[1:0]*8 +: 8] = d.value[7:0];
      o.count = d.count + 3'd1;
    end
    return o;
  endfunction

  // one step of the decimal scanner
  function automatic dec_t feed(input dec_t d, input logic [7:0] c);
    dec_t o;
    logic digit;
    logic [11:0] prod;
    o = d;
    digit = (c >= 8'h30) && (c <= 8'h39);
    prod = 12'(d.value) * 12'd10 + 12'(c - 8'h30);
    if (d.err == ST_OK) begin
      case (d.phase)
        PH_LEAD: begin
          if (!is_blank(c)) begin
            if (digit) begin
              o.value = 9'(c - 8'h30);
              o.phase = PH_NUM;
            end else begin
              o.err = ST_MISSING;
            end
          end
        end
        PH_NUM: begin
          if (digit) begin
            o.value = (prod > 12'd256) ? 9'd256 : prod[8:0];
          end else begin
            o = accept_num(d);
            if (o.err == ST_OK) begin
              o.phase = PH_AFTER;
              o = after_char(o, c);
            end
          end
        end
        PH_AFTER: o = after_char(d, c);
        default: if (!is_blank(c)) o.err = ST_TRAILING;
      endcase
    end
    return o;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'd0;
  endfunction

  // parse state
  logic             seen_r, hash_r, bad_r, comma_r;
  logic [POS_W-1:0] clen_r, pend_r;
  logic [23:0]      nib_r;
  dec_t             dec_r;

  logic             acc, acc_last, blank, flush;
  logic             seen_e, hash_e, bad_e, comma_e;
  logic [POS_W-1:0] clen_e, pend_e, pos_c;
  logic [POS_W:0]   sum;
  logic [23:0]      nib_e;
  logic [4:0]       hv;
  logic [7:0]       folded;
  dec_t             dec_e, dec_b;
  cell_ctl_t        ctl;
  logic [NAME_COUNT-1:0] hits;

  // middle stage
  logic             s1_valid_r, s1_seen_r, s1_hash_r, s1_bad_r, s1_comma_r;
  logic [POS_W-1:0] s1_clen_r;
  logic [23:0]      s1_nib_r;
  dec_t             s1_dec_r;
  logic [NAME_COUNT-1:0] s1_hits_r;

  // output stage
  logic             out_valid_r;
  logic [7:0]       red_r, green_r, blue_r;
  logic [3:0]       status_r;
  logic             out_ld;

  logic [7:0]       red_c, green_c, blue_c;
  logic [3:0]       status_c;
  logic [23:0]      name_rgb;
  logic [ROM_BITS+23:0] rom_w;
  logic [POS_W-1:0] hex_n;
  dec_t             dec_f;

  assign out_ld   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign acc_last = acc && in_spec_last;

  // per-byte next state, held blanks flushed ahead of a non-blank byte
  always_comb begin
    blank  = is_blank(in_spec_char);
    flush  = !blank && (pend_r != '0);
    sum    = {1'b0, clen_r} + (flush ? {1'b0, pend_r} : '0);
    pos_c  = (sum > {1'b0, LEN_SAT}) ? LEN_SAT : sum[POS_W-1:0];
    folded = (in_spec_char >= 8'h41 && in_spec_char <= 8'h5a) ?
             in_spec_char + 8'd32 : in_spec_char;
    hv     = hex_val(in_spec_char);
    seen_e = seen_r;
    hash_e = hash_r;
    bad_e  = bad_r;
    comma_e = comma_r;
    clen_e = clen_r;
    pend_e = pend_r;
    nib_e  = nib_r;
    dec_e  = dec_r;
    dec_b  = flush ? feed(dec_r, CH_SPACE) : dec_r;
    if (blank) begin
      if (seen_r && pend_r < LEN_SAT) pend_e = pend_r + 1'b1;
    end else begin
      pend_e = '0;
      seen_e = 1'b1;
      if (pos_c == '0 && in_spec_char == CH_HASH) hash_e = 1'b1;
      if (flush && hash_r && clen_r <= 6'd6) bad_e = 1'b1;
      if (hash_e && pos_c >= 6'd1 && pos_c <= 6'd6) begin
        if (!hv[4]) bad_e = 1'b1;
        else nib_e[3'(pos_c - 6'd1)*4 +: 4] = hv[3:0];
      end
      if (in_spec_char == CH_COMMA) comma_e = 1'b1;
      dec_e  = feed(dec_b, in_spec_char);
      clen_e = (pos_c == LEN_SAT) ? LEN_SAT : pos_c + 1'b1;
    end
    ctl.commit = acc && !blank;
    ctl.kill   = flush;
    ctl.clear  = acc_last;
    ctl.pos    = pos_c;
    ctl.ch     = folded;
    ctl.clen   = clen_e;
  end

  // row of name cells
  for (genvar i = 0; i < NAME_COUNT; i++) begin : g_cell
    csp_name_cell #(
      .IDX         (i),
      .NAME_MAX_LEN(NAME_MAX_LEN)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .hit  (hits[i])
    );
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n || acc_last) begin
      seen_r  <= 1'b0;
      hash_r  <= 1'b0;
      bad_r   <= 1'b0;
      comma_r <= 1'b0;
      clen_r  <= '0;
      pend_r  <= '0;
      nib_r   <= '0;
      dec_r   <= DEC_RST;
    end else if (acc) begin
      seen_r  <= seen_e;
      hash_r  <= hash_e;
      bad_r   <= bad_e;
      comma_r <= comma_e;
      clen_r  <= clen_e;
      pend_r  <= pend_e;
      nib_r   <= nib_e;
      dec_r   <= dec_e;
    end
  end

  // middle stage: finished spec
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc_last) begin
      s1_valid_r <= 1'b1;
    end else if (out_ld) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_last) begin
      s1_seen_r  <= seen_e;
      s1_hash_r  <= hash_e;
      s1_bad_r   <= bad_e;
      s1_comma_r <= comma_e;
      s1_clen_r  <= clen_e;
      s1_nib_r   <= nib_e;
      s1_dec_r   <= dec_e;
      s1_hits_r  <= hits;
    end
  end

  // result selection
  always_comb begin
    name_rgb = '0;
    rom_w    = '0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      rom_w = name_entry(i);
      if (s1_hits_r[i]) name_rgb = name_rgb | rom_w[ROM_BITS +: 24];
    end
    hex_n    = s1_clen_r - 1'b1;
    red_c    = '0;
    green_c  = '0;
    blue_c   = '0;
    status_c = ST_OK;
    dec_f    = s1_dec_r;
    if (s1_dec_r.err == ST_OK) begin
      case (s1_dec_r.phase)
        PH_LEAD: dec_f.err = ST_MISSING;
        PH_NUM: begin
          dec_f = accept_num(s1_dec_r);
          if (dec_f.err == ST_OK && dec_f.count != 3'd3) dec_f.err = ST_COUNT;
        end
        PH_AFTER: if (s1_dec_r.count != 3'd3) dec_f.err = ST_COUNT;
        default: dec_f.err = ST_OK;
      endcase
    end
    if (!s1_seen_r) begin
      status_c = ST_EMPTY;
    end else if (s1_hash_r) begin
      if (hex_n == 6'd6 || hex_n == 6'd3) begin
        if (s1_bad_r) begin
          status_c = ST_HEX_DIG;
        end else if (hex_n == 6'd6) begin
          red_c   = {s1_nib_r[3:0], s1_nib_r[7:4]};
          green_c = {s1_nib_r[11:8], s1_nib_r[15:12]};
          blue_c  = {s1_nib_r[19:16], s1_nib_r[23:20]};
        end else begin
          red_c   = {2{s1_nib_r[3:0]}};
          green_c = {2{s1_nib_r[7:4]}};
          blue_c  = {2{s1_nib_r[11:8]}};
        end
      end else begin
        status_c = ST_HEX_LEN;
      end
    end else if (s1_comma_r) begin
      status_c = dec_f.err;
      if (dec_f.err == ST_OK) begin
        red_c   = dec_f.store[7:0];
        green_c = dec_f.store[15:8];
        blue_c  = dec_f.store[23:16];
      end
    end else if (s1_hits_r != '0) begin
      red_c   = name_rgb[23:16];
      green_c = name_rgb[15:8];
      blue_c  = name_rgb[7:0];
    end else begin
      status_c = ST_UNKNOWN;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      red_r    <= red_c;
      green_r  <= green_c;
      blue_r   <= blue_c;
      status_r <= status_c;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_red    = red_r;
  assign out_green  = green_r;
  assign out_blue   = blue_r;
  assign out_status = status_r;

  // checks
  `CSP_ASSERT_NOW(a_err_zero_rgb, out_valid_r && (status_r != ST_OK),
                  (red_r == 8'd0) && (green_r == 8'd0) && (blue_r == 8'd0),
                  "error word with nonzero color")
  `CSP_ASSERT_NEXT(a_last_fills_mid, acc_last, s1_valid_r,
                   "last byte did not reach middle stage")
  `CSP_ASSERT_NOW(a_mid_blocked_stalls, s1_valid_r && !out_ld, in_stall,
                  "input taken while middle stage is blocked")
  `CSP_ASSERT_NEXT(a_load_shows, out_ld, out_valid_r,
                   "loaded result not shown")

endmodule

### tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// checks the color spec parser: bytes of hex, decimal and name specs go in
// with random gaps, each finished spec is predicted in the testbench and the
// result words are compared in order against the predictions
// ---------------------------------------------------------------------------
module tb;
  import csp_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] status;
  } color_t;

  // predicts parsed colors and holds the ones still due
  class color_book;
    color_t due[$];
    int errors;
    bit seen, hashm, hexbad, comma;
    int clen, blanks, nib, phase, ccount, cval, cstore, derr;
    bit alive[ROM_SIZE];
    string names[ROM_SIZE];
    color_t cols[ROM_SIZE];

    function new();
      logic [ROM_BITS+23:0] e;
      string s;
      for (int i = 0; i < ROM_SIZE; i++) begin
        e = name_entry(i);
        cols[i].red = e[ROM_BITS+16 +: 8];
        cols[i].green = e[ROM_BITS+8 +: 8];
        cols[i].blue = e[ROM_BITS +: 8];
        cols[i].status = ST_OK;
        s = "";
        for (int p = ROM_CHARS - 1; p >= 0; p--)
          if (e[p*8 +: 8] != 0) s = {s, string'(e[p*8 +: 8])};
        names[i] = s;
      end
      errors = 0;
      clear();
    endfunction

    function void clear();
      seen = 0; hashm = 0; hexbad = 0; comma = 0;
      clen = 0; blanks = 0; nib = 0; phase = 0;
      ccount = 0; cval = 0; cstore = 0; derr = 0;
      foreach (alive[i]) alive[i] = 1;
    endfunction

    function bit blank(int c);
      return c == CH_SPACE || c == CH_TAB;
    endfunction

    function int hexv(int c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void take_number();
      if (cval > 255) begin
        derr = ST_OVER;
        return;
      end
      cstore |= cval << ((ccount & 3) * 8);
      ccount++;
    endfunction

    function void after_num(int c);
      if (blank(c)) return;
      if (c == CH_COMMA) begin
        phase = (ccount < 3) ? 0 : 3;
        return;
      end
      derr = (ccount != 3) ? ST_COUNT : ST_TRAILING;
    endfunction

    function void scan_decimal(int c);
      bit dg;
      dg = c >= "0" && c <= "9";
      if (derr != 0) return;
      case (phase)
        0: begin
          if (blank(c)) return;
          if (dg) begin
            cval = c - "0";
            phase = 1;
          end else derr = ST_MISSING;
        end
        1: begin
          if (dg) begin
            cval = cval * 10 + c - "0";
            if (cval > 256) cval = 256;
            return;
          end
          take_number();
          if (derr != 0) return;
          phase = 2;
          after_num(c);
        end
        2: after_num(c);
        default: if (!blank(c)) derr = ST_TRAILING;
      endcase
    endfunction

    function void add_char(int c);
      int v, f, pos;
      pos = clen;
      if (pos == 0 && c == CH_HASH) hashm = 1;
      if (hashm && pos >= 1 && pos <= 6) begin
        v = hexv(c);
        if (v < 0) hexbad = 1;
        else nib |= v << ((pos - 1) * 4);
      end
      if (c == CH_COMMA) comma = 1;
      scan_decimal(c);
      f = (c >= "A" && c <= "Z") ? c + 32 : c;
      for (int i = 0; i < ROM_SIZE; i++)
        if (alive[i] && (pos >= NAME_MAX_LEN_DEF || pos >= names[i].len() ||
                         f != names[i][pos]))
          alive[i] = 0;
      clen = (pos + 1 > 63) ? 63 : pos + 1;
    endfunction

    function int finish_decimal();
      if (derr != 0) return derr;
      case (phase)
        0: return ST_MISSING;
        1: begin
          take_number();
          if (derr != 0) return derr;
          return (ccount != 3) ? ST_COUNT : ST_OK;
        end
        2: return (ccount != 3) ? ST_COUNT : ST_OK;
        default: return ST_OK;
      endcase
    endfunction

    // note one accepted input word
    function void note_input(logic [7:0] ch, logic last);
      color_t r;
      int n;
      int c;
      c = ch;
      if (blank(c)) begin
        if (seen && blanks < 63) blanks++;
      end else begin
        while (blanks > 0) begin
          add_char(CH_SPACE);
          blanks--;
        end
        seen = 1;
        add_char(c);
      end
      if (!last) return;
      r = '{8'd0, 8'd0, 8'd0, ST_OK};
      if (!seen) r.status = ST_EMPTY;
      else if (hashm) begin
        n = clen - 1;
        if (n == 6 || n == 3) begin
          if (hexbad) r.status = ST_HEX_DIG;
          else if (n == 6) begin
            r.red = {nib[3:0], nib[7:4]};
            r.green = {nib[11:8], nib[15:12]};
            r.blue = {nib[19:16], nib[23:20]};
          end else begin
            r.red = 8'(nib[3:0] * 17);
            r.green = 8'(nib[7:4] * 17);
            r.blue = 8'(nib[11:8] * 17);
          end
        end else r.status = ST_HEX_LEN;
      end else if (comma) begin
        r.status = 4'(finish_decimal());
        if (r.status == ST_OK) begin
          r.red = cstore[7:0];
          r.green = cstore[15:8];
          r.blue = cstore[23:16];
        end
      end else begin
        r.status = ST_UNKNOWN;
        for (int i = 0; i < ROM_SIZE; i++)
          if (alive[i] && names[i].len() == clen && clen <= NAME_MAX_LEN_DEF) begin
            r = cols[i];
            break;
          end
      end
      due.push_back(r);
      clear();
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(color_t got);
      color_t e;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      e = due.pop_front();
      if (got != e) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, actual %p", e, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [7:0] in_spec_char = 0;
  logic in_spec_last = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [7:0] out_red, out_green, out_blue;
  logic [3:0] out_status;
  color_book book = new();
  bit hold_off = 0;
  int words_in = 0;

  color_spec_parser_top u_top (.*);

  always #5 clk = ~clk;

  // gap length: mostly short, a few long
  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // send one word and wait until it is taken
  task send_word(logic [7:0] ch, logic last);
    in_valid <= 1;
    in_spec_char <= ch;
    in_spec_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_input(ch, last);
    words_in++;
    if (words_in > 200 && words_in < 260 || $urandom_range(0, 3) != 0) return;
    for (int g = gap_len(); g > 0; g--) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  task send_spec(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  function string rand_blanks();
    string s;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, ($urandom_range(0, 1) ? " " : "\t")};
    return s;
  endfunction

  function string rand_spec();
    string s, hx;
    int k;
    hx = "0123456789abcdefABCDEF";
    s = "";
    k = $urandom_range(0, 9);
    if (k < 3) begin
      s = "#";
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : ($urandom_range(0, 1) ? 3 : 6))
        s = {s, ($urandom_range(0, 15) == 0) ? "g" : string'(hx[$urandom_range(0, 21)])};
    end else if (k < 6) begin
      for (int i = 0; i < 3 + ($urandom_range(0, 5) == 0); i++) begin
        if (i > 0) s = {s, ","};
        s = {s, rand_blanks()};
        if ($urandom_range(0, 20) != 0)
          s = {s, $sformatf("%0d", $urandom_range(0, 7) == 0 ? $urandom_range(0, 99999)
                                                             : $urandom_range(0, 255))};
        s = {s, rand_blanks()};
      end
      if ($urandom_range(0, 4) == 0) s = {s, ","};
      if ($urandom_range(0, 9) == 0) s = {s, "x"};
    end else if (k < 9) begin
      s = book.names[$urandom_range(0, ROM_SIZE - 1)];
      for (int i = 0; i < s.len(); i++)
        if ($urandom_range(0, 2) == 0 && s[i] >= "a" && s[i] <= "z") s[i] = s[i] - 32;
      if ($urandom_range(0, 7) == 0) s[$urandom_range(0, s.len() - 1)] = "q";
    end else begin
      repeat ($urandom_range(0, 70)) s = {s, string'(byte'($urandom_range(1, 255)))};
    end
    return {rand_blanks(), s, rand_blanks()};
  endfunction

  // stimulus
  initial begin
    int total;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_spec("#000");
    send_spec(" #FfAa09\t");
    send_spec("#12g");
    send_spec("#12 4");
    send_spec("#12345");
    send_spec("255,0,255");
    send_spec(" 1 , 2 ,3 ,");
    send_spec("256,0,0");
    send_spec("1,,2");
    send_spec("1,2");
    send_spec("1,2,3,4");
    send_spec("1,2,3 x");
    send_spec("LightGoldenrodYellow");
    send_spec("navy blue");
    send_spec({"\t", 8'd255, "z"});
    send_spec("  ");
    send_word(8'd0, 1);
    total = 0;
    while (total < 1200) begin
      string s;
      s = rand_spec();
      if (s.len() == 0) s = " ";
      send_spec(s);
      total += s.len();
    end
    in_valid <= 0;
    while (book.due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // long receiver hold-off while input keeps coming
  initial begin
    wait (words_in == 200);
    hold_off = 1;
    repeat (50) @(posedge clk);
    hold_off = 0;
  end

  // receiver stalls and result checks
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.check_result('{out_red, out_green, out_blue, out_status});
    out_stall <= hold_off || ($urandom_range(0, 3) == 0 && $urandom_range(0, 1) == 0);
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
